@@ src/ordered_point_list_core_assert.svh @@
// Assertion macros shared by the ordered point list core.
`ifndef ORDERED_POINT_LIST_CORE_ASSERT_SVH
`define ORDERED_POINT_LIST_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OPL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered point list check failed");

// The consequent must hold in the cycle after the antecedent.
`define OPL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered point list check failed");

`endif

@@ src/opl_pkg.sv @@
// Types, codes and defaults shared by the ordered point list core.
package opl_pkg;

	localparam int OPL_CAPACITY    = 64;
	localparam int OPL_COORD_WIDTH = 32;

	localparam int ACT_W   = 3;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 7;
	localparam int PORT_CW = 32;

	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]          action;
		logic [POS_W-1:0]          position;
		logic signed [PORT_CW-1:0] x_coord;
		logic signed [PORT_CW-1:0] y_coord;
	} opl_in_t;

	typedef struct packed {
		logic [1:0]                status;
		logic                      found;
		logic signed [PORT_CW-1:0] read_x;
		logic signed [PORT_CW-1:0] read_y;
		logic [COUNT_W-1:0]        count;
	} opl_out_t;

	typedef struct packed {
		logic       load;
		logic       set_status;
		logic [1:0] status_code;
		logic       clr;
		logic       up;
		logic       dn;
		logic       put;
		logic       inc;
		logic       dec;
		logic       rd;
		logic       capture;
		logic       emit;
	} opl_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             full;
		logic             pos_over;
		logic             pos_out;
		logic             more_up;
		logic             more_dn;
		logic             out_free;
	} opl_stat_t;

endpackage

@@ src/ordered_point_list_core.sv @@
// Top level of the ordered point list core: controller, datapath and checks.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------------
//   request | req_valid | req_stall | req: action, position, x_coord, y_coord
//   result  | rsp_valid | rsp_stall | rsp: status, found, read_x, read_y, count
//
// Each item goes from idle through a check state to a done state; accepted append
// and insert add a shift-up and a put state, remove a shift-down state and read a
// read-wait state, with one read and one write of the point store per cycle.
// Reset empties the list, not the store.
// A waiting result does not block the next accept; a new result waits in the
// controller until the result register is free.
module ordered_point_list_core import opl_pkg::*; #(
	parameter int CAPACITY    = OPL_CAPACITY,
	parameter int COORD_WIDTH = OPL_COORD_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  opl_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output opl_out_t rsp
);

	opl_cmd_t  cmd;
	opl_stat_t stat;

	opl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	opl_dpath #(
		.CAPACITY    (CAPACITY),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`include "ordered_point_list_core_assert.svh"

	`OPL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	`OPL_ASSERT_NOW(a_found_is_done, rsp_valid && rsp.found, rsp.status == ST_DONE)
	`OPL_ASSERT_NOW(a_full_count, rsp_valid && rsp.status == ST_FULL,
		rsp.count == COUNT_W'(CAPACITY))

endmodule

@@ src/opl_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module opl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/opl_ctrl.sv @@
// Controller state machine that sequences each list operation.
module opl_ctrl import opl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  opl_stat_t stat,
	output opl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_UP    = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_DN    = 3'd4;
	localparam logic [2:0] S_RDW   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				case (stat.action)
					ACT_APPEND, ACT_INSERT: begin
						if (stat.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else if (stat.pos_over) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_RANGE;
						end else begin
							state_d = S_UP;
						end
					end
					ACT_REMOVE: begin
						if (stat.pos_out) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_RANGE;
						end else begin
							state_d = S_DN;
						end
					end
					ACT_READ: begin
						if (stat.pos_out) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_RANGE;
						end else begin
							cmd.rd  = 1'b1;
							state_d = S_RDW;
						end
					end
					ACT_CLEAR: begin
						cmd.clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_UP: begin
				cmd.up = 1'b1;
				if (!stat.more_up) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				cmd.inc = 1'b1;
				state_d = S_DONE;
			end
			S_DN: begin
				cmd.dn = 1'b1;
				if (!stat.more_dn) begin
					cmd.dec = 1'b1;
					state_d = S_DONE;
				end
			end
			S_RDW: begin
				cmd.capture = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

@@ src/opl_dpath.sv @@
// Datapath: item registers, entry count, shift cursor, point store and result register.
module opl_dpath import opl_pkg::*; #(
	parameter int CAPACITY    = OPL_CAPACITY,
	parameter int COORD_WIDTH = OPL_COORD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  opl_in_t   req,
	input  opl_cmd_t  cmd,
	output opl_stat_t stat,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output opl_out_t  rsp
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int DW   = 2 * COORD_WIDTH;

	logic [CW-1:0]          cnt_q;
	logic [ACT_W-1:0]       act_q;
	logic [CMPW-1:0]        pos_q;
	logic [COORD_WIDTH-1:0] x_q;
	logic [COORD_WIDTH-1:0] y_q;
	logic [CW-1:0]          idx_q;
	logic                   pend_q;
	logic [AW-1:0]          wa_q;
	logic [1:0]             st_q;
	logic                   fnd_q;
	logic signed [PORT_CW-1:0] rx_q;
	logic signed [PORT_CW-1:0] ry_q;
	logic                   rsp_valid_q;
	opl_out_t               rsp_q;

	logic [CMPW-1:0] cnt_ext;
	logic [CMPW-1:0] idx_ext;
	logic [CW:0]     idx_nxt;
	logic            go_up;
	logic            go_dn;
	logic            ram_we;
	logic [AW-1:0]   ram_wa;
	logic [DW-1:0]   ram_wd;
	logic            ram_re;
	logic [AW-1:0]   ram_ra;
	logic [DW-1:0]   ram_rd;
	logic [CW-1:0]   idx_m1;
	logic            out_free;

	assign cnt_ext = CMPW'(cnt_q);
	assign idx_ext = CMPW'(idx_q);
	assign idx_nxt = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_m1  = idx_q - CW'(1);

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		stat          = '0;
		stat.action   = act_q;
		stat.full     = (cnt_q == CW'(CAPACITY));
		stat.pos_over = (pos_q > cnt_ext);
		stat.pos_out  = (pos_q >= cnt_ext);
		stat.more_up  = (idx_ext > pos_q);
		stat.more_dn  = (idx_nxt < {1'b0, cnt_q});
		stat.out_free = out_free;
	end

	assign go_up = cmd.up && stat.more_up;
	assign go_dn = cmd.dn && stat.more_dn;

	always_comb begin
		ram_re = go_up || go_dn || cmd.rd;
		if (go_up) begin
			ram_ra = idx_m1[AW-1:0];
		end else if (go_dn) begin
			ram_ra = idx_nxt[AW-1:0];
		end else begin
			ram_ra = pos_q[AW-1:0];
		end
		ram_we = pend_q || cmd.put;
		ram_wa = pend_q ? wa_q : pos_q[AW-1:0];
		ram_wd = pend_q ? ram_rd : {y_q, x_q};
	end

	opl_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			pend_q <= go_up || go_dn;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= req.action;
			x_q   <= COORD_WIDTH'(req.x_coord);
			y_q   <= COORD_WIDTH'(req.y_coord);
			st_q  <= ST_DONE;
			fnd_q <= 1'b0;
			rx_q  <= '0;
			ry_q  <= '0;
			if (req.action == ACT_APPEND) begin
				pos_q <= cnt_ext;
			end else begin
				pos_q <= CMPW'(req.position);
			end
			if (req.action == ACT_REMOVE) begin
				idx_q <= CW'(req.position);
			end else begin
				idx_q <= cnt_q;
			end
		end else begin
			if (go_up) begin
				idx_q <= idx_m1;
			end else if (go_dn) begin
				idx_q <= idx_nxt[CW-1:0];
			end
			if (cmd.set_status) begin
				st_q <= cmd.status_code;
			end
			if (cmd.capture) begin
				fnd_q <= 1'b1;
				rx_q  <= PORT_CW'($signed(ram_rd[COORD_WIDTH-1:0]));
				ry_q  <= PORT_CW'($signed(ram_rd[DW-1:COORD_WIDTH]));
			end
		end
		if (go_up) begin
			wa_q <= idx_q[AW-1:0];
		end else if (go_dn) begin
			wa_q <= idx_q[AW-1:0];
		end
		if (cmd.emit) begin
			rsp_q.status <= st_q;
			rsp_q.found  <= fnd_q;
			rsp_q.read_x <= rx_q;
			rsp_q.read_y <= ry_q;
			rsp_q.count  <= COUNT_W'(cnt_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
